// File: hw/rtl/lcmlt_pkg.sv
// Shared types and constants for the min line tree.
package lcmlt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DOMAIN_LOW  = 2'd0,
    REG_DOMAIN_HIGH = 2'd1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EVAL,
    ST_MUL,
    ST_CMP,
    ST_STEP,
    ST_RESULT
  } state_e;

  localparam logic signed [63:0] EmptyValue = 64'sd1000000000000000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch request and domain
    logic rd;        // read node at current index
    logic eval;      // load evaluation operands
    logic mul;       // register products
    logic cmp;       // register comparisons
    logic step;      // descend or finish
    logic clear;     // empty the tree
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic empty_path;
    logic done;
  } stat_t;

endpackage

// File: hw/rtl/lcmlt_ctrl.sv
// Controller state machine for the min line tree.
module lcmlt_ctrl import lcmlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic [1:0]  req_cmd_i,
  output logic        req_ready_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  input  stat_t       stat_i,
  output cmd_t        cmd_o
);

  state_e state_q, state_d;

  // Hold the state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one request through the node walk.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          case (req_cmd_i)
            CMD_INSERT, CMD_QUERY: begin
              cmd_o.start = 1'b1;
              state_d = ST_READ;
            end
            CMD_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // Finish once the walk has ended at the current node.
        if (stat_i.done) begin
          state_d = ST_RESULT;
        end else if (stat_i.empty_path) begin
          cmd_o.step = 1'b1;
          state_d = ST_RESULT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d = stat_i.done ? ST_RESULT : ST_READ;
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/lcmlt_dp.sv
// Datapath for the min line tree: node memories, evaluation and walk state.
module lcmlt_dp import lcmlt_pkg::*; #(
  parameter int MaxLines   = 4096,
  parameter int DomainBits = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  input  logic [1:0]                   req_cmd_i,
  input  logic signed [31:0]           req_slope_i,
  input  logic signed [62:0]           req_intercept_i,
  input  logic signed [DomainBits-1:0] req_x_i,
  input  logic signed [DomainBits-1:0] dom_low_i,
  input  logic [DomainBits-2:0]        dom_high_i,
  output stat_t                        stat_o,
  output logic signed [63:0]           min_value_o,
  output logic                         store_full_o
);

  localparam int IdxW = $clog2(MaxLines + 1);
  localparam int AdrW = $clog2(MaxLines);
  localparam logic [IdxW-1:0] NullLink = IdxW'(MaxLines);
  localparam int DW = DomainBits + 1;

  // Node memories.
  logic signed [31:0] mem_slope     [MaxLines];
  logic signed [62:0] mem_intercept [MaxLines];
  logic [IdxW-1:0]    mem_left      [MaxLines];
  logic [IdxW-1:0]    mem_right     [MaxLines];

  logic [IdxW-1:0] root_q, count_q, cur_q;
  logic is_query_q, done_q, full_q;
  logic signed [31:0] m_q, rd_m_q;
  logic signed [62:0] c_q, rd_c_q;
  logic [IdxW-1:0] rd_l_q, rd_r_q;
  logic signed [DW-1:0] lo_q, hi_q, mid_q, x_q;
  logic signed [63:0] best_q;
  // Products: new line and stored line at lo, mid, hi (query uses slot 0 at x).
  logic signed [63:0] pn_q [3];
  logic signed [63:0] ps_q [3];
  logic lt_q [3];
  logic signed [63:0] vq_q;

  assign stat_o.is_query   = is_query_q;
  assign stat_o.empty_path = (cur_q == NullLink);
  assign stat_o.done       = done_q;
  assign min_value_o  = is_query_q ? best_q : 64'sd0;
  assign store_full_o = full_q;

  logic signed [DW-1:0] span;
  logic signed [DW-1:0] mid_c;
  assign span  = hi_q - lo_q;
  assign mid_c = lo_q + ((span < 0) ? -((-span) >>> 1) : (span >>> 1));

  // Control registers of the walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= NullLink;
      count_q <= '0;
      cur_q   <= NullLink;
      done_q  <= 1'b0;
      full_q  <= 1'b0;
      is_query_q <= 1'b0;
    end else if (cmd_i.clear) begin
      root_q  <= NullLink;
      count_q <= '0;
    end else if (cmd_i.start) begin
      is_query_q <= (req_cmd_i == CMD_QUERY);
      cur_q  <= root_q;
      done_q <= 1'b0;
      full_q <= 1'b0;
      if (req_cmd_i == CMD_INSERT && root_q == NullLink) begin
        root_q  <= count_q;
        count_q <= count_q + 1'b1;
        done_q  <= 1'b1;
      end
    end else if (cmd_i.step && !(cur_q == NullLink)) begin
      if (is_query_q) begin
        if (x_q <= mid_q) cur_q <= rd_l_q; else cur_q <= rd_r_q;
      end else if (lt_q[0] == lt_q[2]) begin
        done_q <= 1'b1;
      end else begin
        logic go_left;
        logic [IdxW-1:0] lnk;
        go_left = (lt_q[0] != lt_q[1]);
        lnk = go_left ? rd_l_q : rd_r_q;
        if (lnk == NullLink) begin
          done_q <= 1'b1;
          if (count_q >= NullLink) full_q <= 1'b1;
          else count_q <= count_q + 1'b1;
        end else begin
          cur_q <= lnk;
        end
      end
    end else if (cmd_i.step) begin
      done_q <= 1'b1;
    end
  end

  // Payload registers, memory ports and arithmetic.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      m_q <= req_slope_i;
      c_q <= req_intercept_i;
      x_q <= DW'(req_x_i);
      lo_q <= DW'(dom_low_i);
      hi_q <= DW'({1'b0, dom_high_i});
      best_q <= EmptyValue;
      if (req_cmd_i == CMD_INSERT && root_q == NullLink) begin
        mem_slope[count_q[AdrW-1:0]]     <= req_slope_i;
        mem_intercept[count_q[AdrW-1:0]] <= req_intercept_i;
        mem_left[count_q[AdrW-1:0]]  <= NullLink;
        mem_right[count_q[AdrW-1:0]] <= NullLink;
      end
    end
    if (cmd_i.rd) begin
      rd_m_q <= mem_slope[cur_q[AdrW-1:0]];
      rd_c_q <= mem_intercept[cur_q[AdrW-1:0]];
      rd_l_q <= mem_left[cur_q[AdrW-1:0]];
      rd_r_q <= mem_right[cur_q[AdrW-1:0]];
    end
    if (cmd_i.eval) begin
      mid_q <= mid_c;
    end
    if (cmd_i.mul) begin
      if (is_query_q) begin
        pn_q[0] <= 64'(rd_m_q) * 64'(x_q);
      end else begin
        pn_q[0] <= 64'(m_q) * 64'(lo_q);
        pn_q[1] <= 64'(m_q) * 64'(mid_q);
        pn_q[2] <= 64'(m_q) * 64'(hi_q);
        ps_q[0] <= 64'(rd_m_q) * 64'(lo_q);
        ps_q[1] <= 64'(rd_m_q) * 64'(mid_q);
        ps_q[2] <= 64'(rd_m_q) * 64'(hi_q);
      end
    end
    if (cmd_i.cmp) begin
      vq_q <= pn_q[0] + 64'(rd_c_q);
      for (int k = 0; k < 3; k++) begin
        lt_q[k] <= (pn_q[k] + 64'(c_q)) < (ps_q[k] + 64'(rd_c_q));
      end
    end
    if (cmd_i.step && !(cur_q == NullLink)) begin
      if (is_query_q) begin
        if (vq_q < best_q) best_q <= vq_q;
        if (x_q <= mid_q) hi_q <= mid_q; else lo_q <= mid_q + 1'b1;
      end else if (lt_q[0] == lt_q[2]) begin
        if (lt_q[0]) begin
          mem_slope[cur_q[AdrW-1:0]]     <= m_q;
          mem_intercept[cur_q[AdrW-1:0]] <= c_q;
        end
      end else begin
        logic go_left, take;
        logic [IdxW-1:0] lnk;
        logic signed [31:0] nm;
        logic signed [62:0] nc;
        go_left = (lt_q[0] != lt_q[1]);
        take = go_left ? lt_q[2] : lt_q[0];
        lnk = go_left ? rd_l_q : rd_r_q;
        nm = take ? rd_m_q : m_q;
        nc = take ? rd_c_q : c_q;
        if (take) begin
          mem_slope[cur_q[AdrW-1:0]]     <= m_q;
          mem_intercept[cur_q[AdrW-1:0]] <= c_q;
        end
        m_q <= nm;
        c_q <= nc;
        if (go_left) hi_q <= mid_q; else lo_q <= mid_q + 1'b1;
        if (lnk == NullLink && count_q < NullLink) begin
          mem_slope[count_q[AdrW-1:0]]     <= nm;
          mem_intercept[count_q[AdrW-1:0]] <= nc;
          mem_left[count_q[AdrW-1:0]]  <= NullLink;
          mem_right[count_q[AdrW-1:0]] <= NullLink;
          if (go_left) mem_left[cur_q[AdrW-1:0]] <= count_q;
          else mem_right[cur_q[AdrW-1:0]] <= count_q;
        end
      end
    end
  end

endmodule

// File: hw/rtl/li_chao_min_line_tree.sv
// Top level of the min line tree: ports, configuration and assembly.
//  channel | dir | fields
//  s_axis  | in  | tdata: command[1:0], slope[33:2], intercept[96:34], query_x[117:97]
//  m_axis  | out | tdata: min_value[63:0]; tuser: store_full
//  cfg     | in  | index 0 domain_low, 1 domain_high
// One request at a time. Each tree level runs through memory read, wait,
// midpoint, multiply, compare and step.
// Reset empties the tree and loads the default domain.
// The result holds on m_axis until taken; no request is accepted meanwhile.
module li_chao_min_line_tree import lcmlt_pkg::*; #(
  parameter int MaxLines   = 4096,
  parameter int DomainBits = 21
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [8*((97+DomainBits+7)/8)-1:0] s_axis_tdata, // command, slope, intercept, query_x
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // min_value
  output logic          m_axis_tuser,   // store_full
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [DomainBits-1:0] cfg_data_i
);

  logic signed [DomainBits-1:0] dom_low_q;
  logic [DomainBits-2:0]        dom_high_q;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Hold the domain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_low_q  <= DomainBits'(-1000000);
      dom_high_q <= (DomainBits-1)'(1000000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DOMAIN_LOW:  dom_low_q  <= cfg_data_i;
        REG_DOMAIN_HIGH: dom_high_q <= cfg_data_i[DomainBits-2:0];
        default: ;
      endcase
    end
  end

  lcmlt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (s_axis_tvalid),
    .req_cmd_i   (s_axis_tdata[1:0]),
    .req_ready_o (s_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lcmlt_dp #(.MaxLines(MaxLines), .DomainBits(DomainBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i           (cmd),
    .req_cmd_i       (s_axis_tdata[1:0]),
    .req_slope_i     (s_axis_tdata[33:2]),
    .req_intercept_i (s_axis_tdata[96:34]),
    .req_x_i         (s_axis_tdata[97 +: DomainBits]),
    .dom_low_i       (dom_low_q),
    .dom_high_i      (dom_high_q),
    .stat_o          (stat),
    .min_value_o     (m_axis_tdata),
    .store_full_o    (m_axis_tuser)
  );

endmodule
